@@ hdl/psf_pkg.sv @@
// Point slab filter: shared widths, payload types and pipeline control struct.
// No dependencies; imported by every other file of the block.
package psf_pkg;

  localparam int COORD_W     = 32;
  localparam int COMP_W      = 16;
  localparam int AXIS_W      = 3 * COMP_W;
  localparam int PROD_W      = COMP_W + COORD_W;
  localparam int DIST_W      = PROD_W + 3;
  localparam int QSHIFT      = 14;
  localparam int TOL_W       = 31;
  localparam int NUM_W       = 20;
  localparam int IN_TDATA_W  = 3 * COORD_W;
  localparam int OUT_TDATA_W = ((3 * COORD_W + NUM_W + 7) / 8) * 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIST_W-1:0]  dist_t;
  typedef logic        [NUM_W-1:0]   num_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } ctl_t;

endpackage

@@ hdl/point_slab_filter_project.sv @@
// Point slab filter top: config registers, point index counter, four-stage pipeline.
// Each accepted point passes the input, product, sum and result registers in turn.
// Throughput: one point per cycle while out_tready does not stall; three 16x32 dot products registered, then summed.
// Ready follows the output side through the stage valid bits; bubbles are absorbed.
// Reset (synchronous, active low): registers to defaults, index 0, pipeline empty.
// Depends on psf_pkg, psf_dot, psf_slice.
module point_slab_filter_project #(
  parameter int INDEX_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [psf_pkg::IN_TDATA_W-1:0]  in_tdata,   // coord_x, coord_y, coord_z
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [psf_pkg::OUT_TDATA_W-1:0] out_tdata,  // out_a, out_b, out_c, point_number
  output logic                            out_tuser,  // kept
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [psf_pkg::AXIS_W-1:0]      cfg_wdata
);
  import psf_pkg::*;

  localparam logic [2:0] REG_AXIS_X = 3'd0;
  localparam logic [2:0] REG_AXIS_Y = 3'd1;
  localparam logic [2:0] REG_AXIS_Z = 3'd2;
  localparam logic [2:0] REG_OFF_X  = 3'd3;
  localparam logic [2:0] REG_OFF_Y  = 3'd4;
  localparam logic [2:0] REG_OFF_Z  = 3'd5;
  localparam logic [2:0] REG_TOL    = 3'd6;
  localparam logic [2:0] REG_MODE   = 3'd7;

  // unit axes in Q1.14
  localparam logic [AXIS_W-1:0] AXIS_X_RST = AXIS_W'(1 << QSHIFT);
  localparam logic [AXIS_W-1:0] AXIS_Y_RST = AXIS_W'(1 << QSHIFT) << COMP_W;
  localparam logic [AXIS_W-1:0] AXIS_Z_RST = AXIS_W'(1 << QSHIFT) << (2 * COMP_W);

  logic [AXIS_W-1:0] axis_x_r, axis_y_r, axis_z_r;
  coord_t            off_x_r, off_y_r, off_z_r;
  logic [TOL_W-1:0]  tol_r;
  logic              mode_r;

  logic [INDEX_BITS-1:0]       cnt_r, cnt_nxt;
  logic [INDEX_BITS+NUM_W-1:0] cnt_ext;
  num_t                        num_in;

  logic   in_acc;
  logic   rdy1, rdy2, rdy3, rdy4;
  logic   v1_r, v2_r, v3_r;
  coord_t x1_r, y1_r, z1_r, x2_r, y2_r, z2_r, x3_r, y3_r, z3_r;
  logic   last1_r, last2_r, last3_r;
  num_t   num1_r, num2_r, num3_r;
  ctl_t   ctl;
  dist_t  dist_u, dist_v, dist_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r <= AXIS_X_RST;
      axis_y_r <= AXIS_Y_RST;
      axis_z_r <= AXIS_Z_RST;
      off_x_r  <= '0;
      off_y_r  <= '0;
      off_z_r  <= '0;
      tol_r    <= '0;
      mode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AXIS_X: axis_x_r <= cfg_wdata;
        REG_AXIS_Y: axis_y_r <= cfg_wdata;
        REG_AXIS_Z: axis_z_r <= cfg_wdata;
        REG_OFF_X:  off_x_r  <= cfg_wdata[COORD_W-1:0];
        REG_OFF_Y:  off_y_r  <= cfg_wdata[COORD_W-1:0];
        REG_OFF_Z:  off_z_r  <= cfg_wdata[COORD_W-1:0];
        REG_TOL:    tol_r    <= cfg_wdata[TOL_W-1:0];
        REG_MODE:   mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake chain, back to front
  assign rdy4      = !out_tvalid || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign in_acc    = in_tvalid && rdy1;

  assign ctl.ld_prod = rdy2 && v1_r;
  assign ctl.ld_sum  = rdy3 && v2_r;

  // index saturates, restarts after the last point of a cloud
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_tlast) begin
      cnt_nxt = '0;
    end else if (cnt_r != {INDEX_BITS{1'b1}}) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign cnt_ext = (INDEX_BITS+NUM_W)'(cnt_r);
  assign num_in  = cnt_ext[NUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_r <= cnt_nxt;
      end
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x1_r    <= in_tdata[COORD_W-1:0];
      y1_r    <= in_tdata[2*COORD_W-1:COORD_W];
      z1_r    <= in_tdata[3*COORD_W-1:2*COORD_W];
      last1_r <= in_tlast;
      num1_r  <= num_in;
    end
    if (ctl.ld_prod) begin
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      z2_r    <= z1_r;
      last2_r <= last1_r;
      num2_r  <= num1_r;
    end
    if (ctl.ld_sum) begin
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      z3_r    <= z2_r;
      last3_r <= last2_r;
      num3_r  <= num2_r;
    end
  end

  psf_dot u_dot_x (
    .clk      (clk),
    .ctl      (ctl),
    .axis     (axis_x_r),
    .offset   (off_x_r),
    .pt_x     (x1_r),
    .pt_y     (y1_r),
    .pt_z     (z1_r),
    .dist_out (dist_u)
  );

  psf_dot u_dot_y (
    .clk      (clk),
    .ctl      (ctl),
    .axis     (axis_y_r),
    .offset   (off_y_r),
    .pt_x     (x1_r),
    .pt_y     (y1_r),
    .pt_z     (z1_r),
    .dist_out (dist_v)
  );

  psf_dot u_dot_z (
    .clk      (clk),
    .ctl      (ctl),
    .axis     (axis_z_r),
    .offset   (off_z_r),
    .pt_x     (x1_r),
    .pt_y     (y1_r),
    .pt_z     (z1_r),
    .dist_out (dist_z)
  );

  psf_slice u_slice (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (rdy4),
    .valid_in   (v3_r),
    .dist_z     (dist_z),
    .dist_u     (dist_u),
    .dist_v     (dist_v),
    .pt_x       (x3_r),
    .pt_y       (y3_r),
    .pt_z       (z3_r),
    .last       (last3_r),
    .num        (num3_r),
    .mode       (mode_r),
    .tol        (tol_r),
    .out_tvalid (out_tvalid),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tdata  (out_tdata)
  );

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[3*COORD_W-1:0] == '0)
    else $error("rejected point carries non-zero coordinates");

  a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> cnt_r == '0)
    else $error("point index did not restart after last point");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without an output stall");

  a_full_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v1_r && v2_r && v3_r)
    else $error("input stalled with a bubble in the pipeline");

endmodule

@@ hdl/psf_dot.sv @@
// Point slab filter: one axis dot product, products then sum, two register stages.
// Depends on psf_pkg.
module psf_dot (
  input  logic                        clk,
  input  psf_pkg::ctl_t               ctl,
  input  logic [psf_pkg::AXIS_W-1:0]  axis,
  input  psf_pkg::coord_t             offset,
  input  psf_pkg::coord_t             pt_x,
  input  psf_pkg::coord_t             pt_y,
  input  psf_pkg::coord_t             pt_z,
  output psf_pkg::dist_t              dist_out
);
  import psf_pkg::*;

  logic signed [COMP_W-1:0] comp_x, comp_y, comp_z;
  logic signed [PROD_W-1:0] prod_x_nxt, prod_y_nxt, prod_z_nxt;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r, prod_z_r;
  dist_t                    dist_nxt, dist_r;

  assign comp_x = axis[COMP_W-1:0];
  assign comp_y = axis[2*COMP_W-1:COMP_W];
  assign comp_z = axis[3*COMP_W-1:2*COMP_W];

  always_comb begin
    prod_x_nxt = comp_x * pt_x;
    prod_y_nxt = comp_y * pt_y;
    prod_z_nxt = comp_z * pt_z;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      prod_z_r <= prod_z_nxt;
    end
  end

  // offset is Q16.16, products are Q.30
  assign dist_nxt = DIST_W'(prod_x_r) + DIST_W'(prod_y_r) + DIST_W'(prod_z_r)
                    - (DIST_W'(offset) <<< QSHIFT);

  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      dist_r <= dist_nxt;
    end
  end

  assign dist_out = dist_r;

endmodule

@@ hdl/psf_slice.sv @@
// Point slab filter: tolerance test, u/v rounding and saturation, result register.
// Depends on psf_pkg.
module psf_slice (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ld,
  input  logic                            valid_in,
  input  psf_pkg::dist_t                  dist_z,
  input  psf_pkg::dist_t                  dist_u,
  input  psf_pkg::dist_t                  dist_v,
  input  psf_pkg::coord_t                 pt_x,
  input  psf_pkg::coord_t                 pt_y,
  input  psf_pkg::coord_t                 pt_z,
  input  logic                            last,
  input  psf_pkg::num_t                   num,
  input  logic                            mode,
  input  logic [psf_pkg::TOL_W-1:0]       tol,
  output logic                            out_tvalid,
  output logic                            out_tuser,  // kept
  output logic                            out_tlast,
  output logic [psf_pkg::OUT_TDATA_W-1:0] out_tdata   // out_a, out_b, out_c, point_number
);
  import psf_pkg::*;

  localparam int RND_W = DIST_W + 1;
  localparam int RES_W = RND_W - QSHIFT;
  localparam int PAD_W = OUT_TDATA_W - 3 * COORD_W - NUM_W;

  function automatic coord_t project(input dist_t q);
    logic signed [RND_W-1:0]       t;
    logic signed [RES_W-1:0]       r;
    logic [RES_W-COORD_W:0]        hi;
    coord_t                        res;
    t  = RND_W'(q) + RND_W'(1 <<< (QSHIFT - 1));
    r  = RES_W'(t >>> QSHIFT);
    hi = r[RES_W-1:COORD_W-1];
    if (hi == '0 || hi == '1) begin
      res = r[COORD_W-1:0];
    end else if (r[RES_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

  logic [DIST_W-1:0] mag, lim;
  logic              keep;
  coord_t            a_nxt, b_nxt, c_nxt;
  coord_t            a_r, b_r, c_r;
  num_t              num_r;
  logic              kept_r, last_r, valid_r;

  assign mag  = dist_z[DIST_W-1] ? DIST_W'(-dist_z) : DIST_W'(dist_z);
  assign lim  = DIST_W'({tol, {QSHIFT{1'b0}}});
  assign keep = (mag <= lim);

  always_comb begin
    a_nxt = '0;
    b_nxt = '0;
    c_nxt = '0;
    if (keep) begin
      if (mode) begin
        a_nxt = project(dist_u);
        b_nxt = project(dist_v);
      end else begin
        a_nxt = pt_x;
        b_nxt = pt_y;
        c_nxt = pt_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && valid_in) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      c_r    <= c_nxt;
      num_r  <= num;
      kept_r <= keep;
      last_r <= last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = kept_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, num_r, c_r, b_r, a_r};

endmodule

@@ dv/point_slab_filter_project_tb.sv @@
// Self-checking bench for point_slab_filter_project: streams Q16.16 points through the
// slab filter and compares every result beat against an in-bench distance/projection model.
// Depends on psf_pkg and the block's RTL; needs no files or arguments.
module point_slab_filter_project_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psf_pkg::*;

  localparam int          IDX_BITS    = 20;
  localparam int unsigned IDX_MAX     = (1 << IDX_BITS) - 1;
  localparam longint      AXIS_ONE    = 64'sd16384;
  localparam longint      Q16_MAX     = 64'sh7FFF_FFFF;
  localparam longint      Q16_MIN     = -64'sh8000_0000;
  localparam coord_t      C_MAX       = 32'sh7FFF_FFFF;
  localparam coord_t      C_MIN       = 32'sh8000_0000;
  localparam int          QUIET_LIMIT = 1000;
  localparam int          REPORT_MAX  = 100;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_PTS   = 125;

  typedef enum logic [2:0] {
    REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z, REG_OFF_X, REG_OFF_Y, REG_OFF_Z, REG_TOL, REG_MODE
  } reg_e;
  typedef enum logic {MODE_PLANE, MODE_FRAME} mode_e;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } point_t;

  typedef struct {
    logic   kept;
    coord_t a;
    coord_t b;
    coord_t c;
    num_t   num;
    logic   done;
  } slice_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // coord_x, coord_y, coord_z
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // out_a, out_b, out_c, point_number
  logic                   out_tuser;         // kept
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic [2:0]             cfg_index  = '0;
  logic [AXIS_W-1:0]      cfg_wdata  = '0;

  // bench copy of the register file and point index
  logic [AXIS_W-1:0] axis_m [3];
  coord_t            off_m  [3];
  logic [TOL_W-1:0]  tol_m;
  mode_e             mode_m;
  int unsigned       idx_count;
  logic [AXIS_W-1:0] next_setting [8];

  point_t      cloud_q[$];
  slice_t      filtered_q[$];
  point_t      cur_pt;
  bit          cur_busy   = 1'b0;
  bit          idle_en    = 1'b1;
  int          gap_left   = 0;
  int          stall_left = 0;
  int          quiet      = 0;
  int unsigned err_cnt    = 0;
  int unsigned beats_in   = 0;
  int unsigned kept_cnt   = 0;
  int unsigned settings   = 0;

  point_slab_filter_project #(.INDEX_BITS(IDX_BITS)) dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint axis_dot(logic [AXIS_W-1:0] ax, point_t p);
    longint acc;
    acc = longint'($signed(ax[15:0])) * longint'(p.x);
    acc += longint'($signed(ax[31:16])) * longint'(p.y);
    acc += longint'($signed(ax[47:32])) * longint'(p.z);
    return acc;
  endfunction

  // Q.30 to Q16.16, round half up, clamp to 32 bits
  function automatic coord_t round_sat(longint q30);
    longint r;
    r = (q30 + (AXIS_ONE >>> 1)) >>> QSHIFT;
    if (r > Q16_MAX) r = Q16_MAX;
    else if (r < Q16_MIN) r = Q16_MIN;
    return r[31:0];
  endfunction

  function automatic slice_t slab_filter_point(point_t p);
    slice_t r;
    longint plane_d;
    longint mag;
    plane_d = axis_dot(axis_m[2], p) - longint'(off_m[2]) * AXIS_ONE;
    mag     = (plane_d < 0) ? -plane_d : plane_d;
    r.kept  = (mag <= longint'(tol_m) * AXIS_ONE);
    r.a     = '0;
    r.b     = '0;
    r.c     = '0;
    if (r.kept && mode_m == MODE_PLANE) begin
      r.a = p.x;
      r.b = p.y;
      r.c = p.z;
    end else if (r.kept) begin
      r.a = round_sat(axis_dot(axis_m[0], p) - longint'(off_m[0]) * AXIS_ONE);
      r.b = round_sat(axis_dot(axis_m[1], p) - longint'(off_m[1]) * AXIS_ONE);
    end
    r.num  = idx_count[NUM_W-1:0];
    r.done = p.last;
    if (p.last) idx_count = 0;
    else if (idx_count < IDX_MAX) idx_count++;
    return r;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endfunction

  function automatic void queue_point(coord_t x, coord_t y, coord_t z, logic last);
    point_t p;
    p = '{x, y, z, last};
    cloud_q.insert(cloud_q.size(), p);
  endfunction

  function automatic logic [15:0] tilt();
    int v;
    v = $urandom_range(0, 8190);
    v = v - 4095;
    return v[15:0];
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return '1;
      default: return 32'sd1;
    endcase
  endfunction

  // Mostly points placed about the slab boundary when the normal is near the z axis,
  // the rest extremes and full-range noise.
  function automatic point_t gen_point(int unsigned end_odds);
    point_t      p;
    longint      span;
    longint      base;
    int unsigned kind;
    logic [15:0] nz;
    kind   = $urandom_range(0, 9);
    nz     = axis_m[2][47:32];
    p.last = ($urandom_range(1, end_odds) == 1);
    if (kind == 0) begin
      p.x = pick_extreme();
      p.y = pick_extreme();
      p.z = pick_extreme();
    end else if (kind < 3) begin
      p.x = $urandom;
      p.y = $urandom;
      p.z = $urandom;
    end else begin
      p.x = $urandom_range(0, 2**21) - 2**20;
      p.y = $urandom_range(0, 2**21) - 2**20;
      p.z = $urandom_range(0, 2**21) - 2**20;
      if (nz == 16'h4000 || nz == 16'hC000) begin
        p.z  = '0;
        span = (tol_m > 2**20) ? 2**20 : tol_m;
        base = longint'(off_m[2]) - (axis_dot(axis_m[2], p) >>> QSHIFT)
               + longint'($urandom_range(0, 2 * span + 4)) - (span + 2);
        if (nz == 16'hC000) base = -base;
        p.z = base[31:0];
      end
    end
    return p;
  endfunction

  task automatic write_reg(input reg_e idx, input logic [AXIS_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z: axis_m[idx] = val;
      REG_OFF_X, REG_OFF_Y, REG_OFF_Z: off_m[idx - REG_OFF_X] = val[31:0];
      REG_TOL: tol_m = val[TOL_W-1:0];
      default: mode_m = mode_e'(val[0]);
    endcase
  endtask

  task automatic load_setting();
    for (int i = 0; i < 8; i++) write_reg(reg_e'(i), next_setting[i]);
    settings++;
  endtask

  task automatic random_setting();
    for (int i = 0; i < 8; i++) next_setting[i] = AXIS_W'({$urandom, $urandom});
    if ($urandom_range(0, 1)) next_setting[REG_AXIS_X] = {tilt(), tilt(), 16'h4000};
    if ($urandom_range(0, 1)) next_setting[REG_AXIS_Y] = {tilt(), 16'h4000, tilt()};
    if ($urandom_range(0, 3) != 0)
      next_setting[REG_AXIS_Z] = {($urandom_range(0, 1) ? 16'hC000 : 16'h4000), tilt(), tilt()};
    if ($urandom_range(0, 3) != 0)
      next_setting[REG_OFF_Z][31:0] = $urandom_range(0, 2**17) - 2**16;
    case ($urandom_range(0, 3))
      0: next_setting[REG_TOL][TOL_W-1:0] = '0;
      1: next_setting[REG_TOL][TOL_W-1:0] = TOL_W'($urandom_range(0, 2000));
      2: next_setting[REG_TOL][TOL_W-1:0] = '1;
      default: ;
    endcase
    load_setting();
  endtask

  task automatic drain();
    while (cloud_q.size() != 0 || cur_busy || filtered_q.size() != 0) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        filtered_q.insert(filtered_q.size(), slab_filter_point(cur_pt));
        if (filtered_q[$].kept) kept_cnt++;
        beats_in++;
        cur_busy = 1'b0;
      end
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (cloud_q.size() != 0) begin
        cur_pt = cloud_q.pop_front();
        cur_busy = 1'b1;
        in_tdata  <= {cur_pt.z, cur_pt.y, cur_pt.x};
        in_tlast  <= cur_pt.last;
        in_tvalid <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 7);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    slice_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("%0t: result beat with nothing expected, got %h", $time, out_tdata);
        end else begin
          want = filtered_q.pop_front();
          check_field("kept", want.kept, out_tuser);
          check_field("out_a", want.a, out_tdata[COORD_W-1:0]);
          check_field("out_b", want.b, out_tdata[2*COORD_W-1:COORD_W]);
          check_field("out_c", want.c, out_tdata[3*COORD_W-1:2*COORD_W]);
          check_field("point_number", want.num, out_tdata[3*COORD_W+NUM_W-1:3*COORD_W]);
          check_field("cloud_done", want.done, out_tlast);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned odds;
    point_t      gp;
    axis_m    = '{48'h4000, 48'h4000_0000, 48'h4000_0000_0000};
    off_m     = '{default: '0};
    tol_m     = '0;
    mode_m    = MODE_PLANE;
    idx_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: plane mode, zero tolerance, normal along z
    queue_point(C_MIN, C_MAX, 0, 1'b0);
    queue_point(C_MAX, C_MIN, 0, 1'b0);
    queue_point(1, 2, 1, 1'b0);
    queue_point(5, 6, C_MIN, 1'b1);
    queue_point(-1, -1, 0, 1'b1);
    drain();

    // tolerance edges either side of an offset plane
    write_reg(REG_OFF_Z, 48'd1000);
    write_reg(REG_TOL, 48'd50);
    queue_point(7, -3, 1050, 1'b0);
    queue_point(7, -3, 1051, 1'b0);
    queue_point(0, 0, 950, 1'b0);
    queue_point(0, 0, 949, 1'b1);
    drain();

    // frame mode with extreme axes and offsets: u and v saturate both ways
    next_setting = '{{3{16'h7FFF}}, {3{16'h8000}}, 48'h0, 48'h7FFF_FFFF, 48'h8000_0000,
                     48'h0, 48'h7FFF_FFFF, 48'(MODE_FRAME)};
    load_setting();
    queue_point(C_MAX, C_MAX, C_MAX, 1'b0);
    queue_point(C_MIN, C_MIN, C_MIN, 1'b0);
    queue_point(0, 0, 0, 1'b1);
    drain();

    // rounding at the half step, then a rejected point in frame mode
    next_setting = '{48'h1, 48'hFFFF, 48'h0001_0000_0000, 48'h0, 48'h0, 48'h0, 48'h0,
                     48'(MODE_FRAME)};
    load_setting();
    queue_point(8192, $urandom, 0, 1'b0);
    queue_point(-8192, $urandom, 0, 1'b0);
    queue_point(8191, $urandom, 0, 1'b0);
    queue_point(-8193, $urandom, 0, 1'b0);
    queue_point(3, 4, 5, 1'b1);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_en = (ph < RAND_PHASES - 1);
      random_setting();
      odds = 4 << (2 * $urandom_range(0, 2));
      for (int n = 0; n < PHASE_PTS; n++) begin
        if (n == PHASE_PTS / 2) drain();
        gp = gen_point(odds);
        cloud_q.insert(cloud_q.size(), gp);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (filtered_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected results never arrived", $time, filtered_q.size());
    end
    $display("%0d points over %0d register settings, %0d kept, %0d mismatches;",
             beats_in, settings, kept_cnt, err_cnt);
    $display("tolerance edges, saturating and half-step projections, random stalls both ends.");
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/psf_pkg.sv
hdl/psf_dot.sv
hdl/psf_slice.sv
hdl/point_slab_filter_project.sv
dv/point_slab_filter_project_tb.sv
